FILE: src/sha2_pkg.sv
// Shared types, round constants, initial values and sigma functions for the SHA-2 engine.
package sha2_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic push;
    logic step;
  } sched_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } round_ctrl_t;

  localparam int unsigned ROUNDS = 64;
  localparam logic MODE_SHA256 = 1'b0;
  localparam logic MODE_SHA224 = 1'b1;
  localparam word_t PAD_MARKER = 32'h8000_0000;

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic hash_t iv_of(input logic mode);
    hash_t h;
    if (mode == MODE_SHA224) begin
      h[0] = 32'hc1059ed8; h[1] = 32'h367cd507; h[2] = 32'h3070dd17; h[3] = 32'hf70e5939;
      h[4] = 32'hffc00b31; h[5] = 32'h68581511; h[6] = 32'h64f98fa7; h[7] = 32'hbefa4fa4;
    end else begin
      h[0] = 32'h6a09e667; h[1] = 32'hbb67ae85; h[2] = 32'h3c6ef372; h[3] = 32'ha54ff53a;
      h[4] = 32'h510e527f; h[5] = 32'h9b05688c; h[6] = 32'h1f83d9ab; h[7] = 32'h5be0cd19;
    end
    return h;
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'd0, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

FILE: src/sha2_sched.sv
// Sixteen-word block buffer that also rolls out the message schedule during the rounds.
module sha2_sched (
  input  logic                 clk,
  input  sha2_pkg::sched_ctrl_t ctrl,
  input  sha2_pkg::word_t      push_word,
  output sha2_pkg::word_t      w_cur
);
  import sha2_pkg::*;

  word_t win [16];
  word_t w_next;

  // The oldest word sits at index 0 and is the schedule word of the current round.
  assign w_next = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  assign w_cur  = win[0];

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= ctrl.push ? push_word : w_next;
    end
  end

endmodule

FILE: src/sha2_round.sv
// Working variables a to h and the compression round that updates them once per cycle while stepping.
module sha2_round (
  input  logic                 clk,
  input  sha2_pkg::round_ctrl_t ctrl,
  input  sha2_pkg::hash_t      cv,
  input  sha2_pkg::word_t      k,
  input  sha2_pkg::word_t      w,
  output sha2_pkg::hash_t      vars
);
  import sha2_pkg::*;

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  always_comb begin
    ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1  = vars[7] + big_sigma1(vars[4]) + ch + k + w;
    t2  = big_sigma0(vars[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      vars <= cv;
    end else if (ctrl.step) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

endmodule

FILE: src/sha224_sha256_hash_engine_top.sv
// Top level of the SHA-256 / SHA-224 engine: sequencer, chaining value and stream ports.
//
//   Channel  Dir  Handshake          Contents
//   s_*      in   s_tvalid/s_tready  message word, byte count, tlast = last word
//   m_*      out  m_tvalid/m_tready  digest word, word index, tlast = final digest word
//   cfg_*    in   cfg_wr_en          digest mode (0 = SHA-256, 1 = SHA-224)
//
// A word that does not complete a block is pushed into the buffer; the sixteenth word of a
// block starts the 64 rounds of the shared round unit, whose result is then folded into the
// chaining value. A last word adds one push per padding word plus one or two compressions,
// then the digest leaves one word per transaction (eight or seven).
// The input is not ready while a compression, padding or digest output is in progress.
// Reset is synchronous and loads the SHA-256 initial values.
module sha224_sha256_hash_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] message_word, [34:32] byte_count, rest zero
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);
  import sha2_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_FIN, S_OUT} state_t;

  state_t      state;
  logic        mode;
  hash_t       cv;
  logic [63:0] bits;
  logic [3:0]  fill;
  logic [5:0]  rnd;
  logic [2:0]  out_idx;
  logic        need_marker;
  logic        hi_sent;
  logic        pad_active;
  logic        final_blk;

  logic        s_acc;
  logic        m_acc;
  logic [2:0]  cnt_sat;
  word_t       in_word;
  word_t       tail_word;
  logic        push_en;
  word_t       push_data;
  logic [2:0]  last_idx;
  hash_t       vars;
  word_t       w_cur;
  sched_ctrl_t sched_ctrl;
  round_ctrl_t round_ctrl;

  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;
  assign in_word  = s_tdata[31:0];
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign last_idx = (mode == MODE_SHA224) ? 3'd6 : 3'd7;
  assign m_tlast  = (out_idx == last_idx);
  assign m_tdata  = {5'd0, out_idx, cv[out_idx]};

  always_comb begin
    cnt_sat = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
    case (cnt_sat)
      3'd0:    tail_word = PAD_MARKER;
      3'd1:    tail_word = {in_word[31:24], 24'h80_0000};
      3'd2:    tail_word = {in_word[31:16], 16'h8000};
      3'd3:    tail_word = {in_word[31:8], 8'h80};
      default: tail_word = in_word;
    endcase

    push_en   = 1'b0;
    push_data = '0;
    if (state == S_IDLE && s_acc) begin
      push_en   = 1'b1;
      push_data = s_tlast ? tail_word : in_word;
    end else if (state == S_PAD) begin
      push_en = 1'b1;
      if (need_marker) begin
        push_data = PAD_MARKER;
      end else if (hi_sent) begin
        push_data = bits[31:0];
      end else if (fill == 4'd14) begin
        push_data = bits[63:32];
      end else begin
        push_data = '0;
      end
    end

    sched_ctrl.push = push_en;
    sched_ctrl.step = (state == S_ROUND);
    round_ctrl.load = push_en && (fill == 4'd15);
    round_ctrl.step = (state == S_ROUND);
  end

  sha2_sched u_sched (
    .clk       (clk),
    .ctrl      (sched_ctrl),
    .push_word (push_data),
    .w_cur     (w_cur)
  );

  sha2_round u_round (
    .clk  (clk),
    .ctrl (round_ctrl),
    .cv   (cv),
    .k    (ROUND_K[rnd]),
    .w    (w_cur),
    .vars (vars)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode        <= MODE_SHA256;
      cv          <= iv_of(MODE_SHA256);
      bits        <= '0;
      fill        <= '0;
      rnd         <= '0;
      out_idx     <= '0;
      need_marker <= 1'b0;
      hi_sent     <= 1'b0;
      pad_active  <= 1'b0;
      final_blk   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            if (s_tlast) begin
              bits        <= bits + {58'd0, cnt_sat, 3'd0};
              need_marker <= (cnt_sat == 3'd4);
              hi_sent     <= 1'b0;
              pad_active  <= 1'b1;
              final_blk   <= 1'b0;
              state       <= S_PAD;
            end else begin
              bits       <= bits + 64'd32;
              pad_active <= 1'b0;
            end
          end
        end
        S_PAD: begin
          if (need_marker) begin
            need_marker <= 1'b0;
          end else if (hi_sent) begin
            // The low length word always completes the final block.
            final_blk <= 1'b1;
          end else if (fill == 4'd14) begin
            hi_sent <= 1'b1;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'(ROUNDS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) begin
            cv[i] <= cv[i] + vars[i];
          end
          out_idx <= '0;
          if (final_blk) begin
            state <= S_OUT;
          end else if (pad_active) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (m_acc) begin
            if (m_tlast) begin
              cv         <= iv_of(mode);
              bits       <= '0;
              fill       <= '0;
              pad_active <= 1'b0;
              final_blk  <= 1'b0;
              state      <= S_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // A pushed word that fills the block starts a compression.
      if (push_en) begin
        if (fill == 4'd15) begin
          fill  <= '0;
          rnd   <= '0;
          state <= S_ROUND;
        end else begin
          fill <= fill + 4'd1;
        end
      end

      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
        cv   <= iv_of(cfg_wr_data);
        bits <= '0;
        fill <= '0;
      end
    end
  end

endmodule

FILE: src/sha2_checker.sv
// Port-level checker for the SHA-2 engine and the bind that attaches it to the top level.
module sha2_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_wr_en
);

  // A stalled digest word holds unless the mode is rewritten under it.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !cfg_wr_en |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled digest transaction changed");

  // Input and output never open together: one message is handled at a time.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while digest is pending");

  // The last word of a message always starts padding (after a compression if it fills the block), so the input closes.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready && !m_tvalid)
    else $error("input still open after last word");

  // The final digest word sits at index six or seven, with zero padding bits.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[34:32] == 3'd6 || m_tdata[34:32] == 3'd7)
                            && m_tdata[39:35] == 5'd0)
    else $error("bad index on final digest word");

  // Once the final digest word is taken, the engine is ready for the next message.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("engine did not reopen after digest");

endmodule

bind sha224_sha256_hash_engine_top sha2_checker u_sha2_checker (.*);
